// ----- sv/cic_pkg.sv -----
`default_nettype none

package cic_pkg;

  localparam int MAX_STAGES_DEF = 8;
  localparam int MAX_FACTOR_DEF = 64;

  localparam int SAMP_W     = 18;
  localparam int ACC_W      = 64;
  localparam int GAIN_W     = 32;
  localparam int FACTOR_W   = 7;
  localparam int STAGES_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_INTERP_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_COMP     = 2'd2;

  localparam logic [FACTOR_W-1:0] FACTOR_RST = 7'd8;
  localparam logic [STAGES_W-1:0] STAGES_RST = 4'd3;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 32'h0200_0000;

  typedef struct packed {
    logic [ACC_W-1:0] re;
    logic [ACC_W-1:0] im;
  } cplx_t;

  typedef struct packed {
    logic  vld;
    logic  last;
    cplx_t data;
  } token_t;

endpackage

`default_nettype wire

// ----- sv/cic_if.sv -----
`default_nettype none

interface cic_in_if import cic_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SAMP_W-1:0] sample_re;
  logic signed [SAMP_W-1:0] sample_im;

  modport source (output valid, sample_re, sample_im, input ready);
  modport sink (input valid, sample_re, sample_im, output ready);
endinterface

interface cic_out_if import cic_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SAMP_W-1:0] out_re;
  logic signed [SAMP_W-1:0] out_im;
  logic                     last;

  modport source (output valid, out_re, out_im, last, input ready);
  modport sink (input valid, out_re, out_im, last, output ready);
endinterface

interface cic_cfg_if import cic_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/cic_comb_cell.sv -----
`default_nettype none

module cic_comb_cell import cic_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   active,
  input  wire token_t tok_in,
  output token_t      tok_out
);

  cplx_t delay;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
      delay       <= '0;
    end else begin
      tok_out.vld  <= tok_in.vld;
      tok_out.last <= tok_in.last;
      if (tok_in.vld) begin
        if (active) begin
          tok_out.data.re <= tok_in.data.re - delay.re;
          tok_out.data.im <= tok_in.data.im - delay.im;
          delay           <= tok_in.data;
        end else begin
          tok_out.data <= tok_in.data;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/cic_integ_cell.sv -----
`default_nettype none

module cic_integ_cell import cic_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   adv,
  input  wire logic   active,
  input  wire token_t tok_in,
  output token_t      tok_out
);

  cplx_t acc;
  cplx_t sum;

  always_comb begin
    sum.re = tok_in.data.re + acc.re;
    sum.im = tok_in.data.im + acc.im;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
      acc         <= '0;
    end else if (adv) begin
      tok_out.vld  <= tok_in.vld;
      tok_out.last <= tok_in.last;
      if (tok_in.vld) begin
        if (active) begin
          acc          <= sum;
          tok_out.data <= sum;
        end else begin
          tok_out.data <= tok_in.data;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/cic_scale.sv -----
`default_nettype none

module cic_scale import cic_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire logic [GAIN_W-1:0] gain,
  input  wire token_t            tok_in,
  output logic                   vld,
  output logic                   last,
  output logic [SAMP_W-1:0]      res_re,
  output logic [SAMP_W-1:0]      res_im
);

  localparam int HALF_W = ACC_W / 2;
  localparam int SUM_W  = ACC_W + 2;
  localparam int SHIFT  = 15;

  function automatic logic signed [ACC_W-1:0] mul_hi(input logic [ACC_W-1:0] acc,
                                                     input logic [GAIN_W-1:0] g);
    logic signed [ACC_W:0] p;
    p = $signed(acc[ACC_W-1:HALF_W]) * $signed({1'b0, g});
    return p[ACC_W-1:0];
  endfunction

  function automatic logic [ACC_W-1:0] mul_lo(input logic [ACC_W-1:0] acc,
                                              input logic [GAIN_W-1:0] g);
    logic [ACC_W-1:0] p;
    p = ACC_W'(acc[HALF_W-1:0]) * ACC_W'(g);
    return p;
  endfunction

  function automatic logic [SAMP_W-1:0] round_sat(input logic [ACC_W-1:0] a,
                                                  input logic [ACC_W-1:0] b);
    logic signed [SUM_W-1:0] c;
    logic signed [SUM_W-1:0] q;
    logic [SAMP_W-1:0]       r;
    c = $signed({{2{a[ACC_W-1]}}, a}) + $signed({{(SUM_W-HALF_W){1'b0}}, b[ACC_W-1:HALF_W]})
        + $signed(SUM_W'(16384));
    q = c >>> SHIFT;
    if (q > $signed(SUM_W'(131071))) begin
      r = 18'h1FFFF;
    end else if (q < -$signed(SUM_W'(131072))) begin
      r = 18'h20000;
    end else begin
      r = q[SAMP_W-1:0];
    end
    return r;
  endfunction

  logic             p_vld;
  logic             p_last;
  logic [ACC_W-1:0] a_re;
  logic [ACC_W-1:0] b_re;
  logic [ACC_W-1:0] a_im;
  logic [ACC_W-1:0] b_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
      vld   <= 1'b0;
    end else if (adv) begin
      p_vld  <= tok_in.vld;
      p_last <= tok_in.last;
      a_re   <= mul_hi(tok_in.data.re, gain);
      b_re   <= mul_lo(tok_in.data.re, gain);
      a_im   <= mul_hi(tok_in.data.im, gain);
      b_im   <= mul_lo(tok_in.data.im, gain);
      vld    <= p_vld;
      last   <= p_last;
      res_re <= round_sat(a_re, b_re);
      res_im <= round_sat(a_im, b_im);
    end
  end

endmodule

`default_nettype wire

// ----- sv/cic_interpolator.sv -----
`default_nettype none

// Complex CIC interpolator. Requests arrive on the sample channel, one
// complex Q2.16 sample each, and every request yields R result requests
// (R from the interp_factor register, limited to 1 to MAX_FACTOR) on the
// result channel, the final one flagged by last. The configuration channel
// writes interp_factor, stage_count and gain_comp by index; it is always
// ready, and writes are only to be made while the block is idle.
// A sample runs through a row of MAX_STAGES comb cells, one cell per cycle.
// A generator then feeds R tokens, the sample followed by zeros, into a row
// of MAX_STAGES integrator cells, followed by a two-stage gain, rounding and
// saturation unit. A result follows its sample through the head register,
// comb row, hold and generator registers, integrator row and scaling
// stages. One sample is taken at a time: the next is accepted once all R
// tokens are fed to the integrators, one per cycle when the receiver does
// not stall; on a stall the integrator row and output stages hold and the
// generator waits. Reset clears all comb and integrator state, loads the
// register defaults (R = 8, N = 3, gain 1/64) and empties the pipeline.
module cic_interpolator import cic_pkg::*; #(
  parameter int MAX_STAGES = MAX_STAGES_DEF,
  parameter int MAX_FACTOR = MAX_FACTOR_DEF
) (
  input wire logic clk,
  input wire logic rst,
  cic_in_if.sink   sample,
  cic_out_if.source result,
  cic_cfg_if.sink  cfg
);

  localparam int CNT_W = $clog2(MAX_FACTOR + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_COMB, ST_EMIT} state_t;

  function automatic logic [ACC_W-1:0] widen(input logic signed [SAMP_W-1:0] x);
    logic signed [SAMP_W-1:0] c;
    c = x;
    if (x > 18'sd65536) begin
      c = 18'sd65536;
    end else if (x < -18'sd65536) begin
      c = -18'sd65536;
    end
    return {{(ACC_W - SAMP_W - 16){c[SAMP_W-1]}}, c, 16'd0};
  endfunction

  logic [FACTOR_W-1:0] interp_factor;
  logic [STAGES_W-1:0] stage_count;
  logic [GAIN_W-1:0]   gain_comp;

  state_t            state;
  token_t            head;
  token_t            gen;
  cplx_t             x_hold;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  r_eff;
  logic              adv;
  logic              k_last;
  logic [MAX_STAGES-1:0] stage_en;
  logic [MAX_STAGES:0]   comb_vld;

  token_t comb_tok  [MAX_STAGES+1];
  token_t integ_tok [MAX_STAGES+1];

  assign cfg.ready    = 1'b1;
  assign sample.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_factor <= FACTOR_RST;
      stage_count   <= STAGES_RST;
      gain_comp     <= GAIN_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_INTERP_FACTOR: interp_factor <= cfg.data[FACTOR_W-1:0];
        REG_STAGE_COUNT:   stage_count   <= cfg.data[STAGES_W-1:0];
        REG_GAIN_COMP:     gain_comp     <= cfg.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (interp_factor == '0) begin
      r_eff = CNT_W'(1);
    end else if (interp_factor > FACTOR_W'(MAX_FACTOR)) begin
      r_eff = CNT_W'(MAX_FACTOR);
    end else begin
      r_eff = CNT_W'(interp_factor);
    end
  end

  assign k_last = (k == CNT_W'(r_eff - 1'b1));
  assign adv    = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head.vld <= 1'b0;
      gen.vld  <= 1'b0;
      k        <= '0;
    end else begin
      head.vld <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            head.vld     <= 1'b1;
            head.last    <= 1'b0;
            head.data.re <= widen(sample.sample_re);
            head.data.im <= widen(sample.sample_im);
            state        <= ST_COMB;
          end
        end
        ST_COMB: begin
          if (comb_tok[MAX_STAGES].vld) begin
            x_hold <= comb_tok[MAX_STAGES].data;
            k      <= '0;
            state  <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (adv) begin
            k <= k + 1'b1;
            if (k_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (adv) begin
        gen.vld  <= (state == ST_EMIT);
        gen.last <= k_last;
        gen.data <= (k == '0) ? x_hold : '0;
      end
    end
  end

  assign comb_tok[0]  = head;
  assign integ_tok[0] = gen;

  for (genvar j = 0; j < MAX_STAGES; j++) begin : g_cells
    assign stage_en[j] = (int'(stage_count) > j);

    cic_comb_cell u_comb (
      .clk     (clk),
      .rst     (rst),
      .active  (stage_en[j]),
      .tok_in  (comb_tok[j]),
      .tok_out (comb_tok[j+1])
    );

    cic_integ_cell u_integ (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .active  (stage_en[j]),
      .tok_in  (integ_tok[j]),
      .tok_out (integ_tok[j+1])
    );
  end

  for (genvar j = 0; j <= MAX_STAGES; j++) begin : g_vld
    assign comb_vld[j] = comb_tok[j].vld;
  end

  cic_scale u_scale (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .gain   (gain_comp),
    .tok_in (integ_tok[MAX_STAGES]),
    .vld    (result.valid),
    .last   (result.last),
    .res_re (result.out_re),
    .res_im (result.out_im)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> !sample.ready)
    else $error("sample accepted while a request was still in progress");

  a_comb_token: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMB) |-> $onehot(comb_vld))
    else $error("comb row does not hold exactly one token");

  a_comb_empty: assert property (@(posedge clk) disable iff (rst)
    (state != ST_COMB) |-> (comb_vld == '0))
    else $error("comb row holds a token outside the comb phase");

  a_emit_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && adv && k_last |=> (state == ST_IDLE) && gen.vld && gen.last)
    else $error("generator did not close the burst with a flagged token");

endmodule

`default_nettype wire
